// ===== hdl/u2cp_pkg.sv =====
// ----------------------------------------------------------------------------
// u2cp_pkg
// Types and constants shared by the UTF-8 to code point decoder modules.
// ----------------------------------------------------------------------------
package u2cp_pkg;

  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  // lead and continuation byte prefixes, compared against the top bits of the byte
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_error;
    logic            last_of_run;
    logic            string_done;
  } result_t;

  // one entry per input byte that causes results: pre_errs replacement
  // beats, then one decoded value if has_val
  typedef struct packed {
    logic [2:0]      pre_errs;
    logic            has_val;
    logic            done;
    logic [CP_W-1:0] val;
  } cmd_t;

endpackage

// ===== hdl/u2cp_front.sv =====
// ----------------------------------------------------------------------------
// u2cp_front
// Byte classifier: tracks the pending sequence and turns each byte into a
// command for the result expander.
// ----------------------------------------------------------------------------
module u2cp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  u2cp_pkg::item_t item,
  output logic            cmd_push,
  output u2cp_pkg::cmd_t  cmd
);

  logic [1:0]                bytes_needed, bytes_needed_next;
  logic [1:0]                bytes_buffered, bytes_buffered_next;
  logic [u2cp_pkg::CP_W-1:0] partial_value, partial_value_next;

  logic [7:0]                b;
  logic [2:0]                flush_n;
  logic [2:0]                pre;
  logic                      has_val;
  logic [u2cp_pkg::CP_W-1:0] val;
  logic [u2cp_pkg::CP_W-1:0] shifted;

  assign b       = item.data_byte;
  assign flush_n = (bytes_needed != 2'd0) ? (3'd1 + {1'b0, bytes_buffered}) : 3'd0;
  assign shifted = {partial_value[u2cp_pkg::CP_W-7:0], b[5:0]};

  always_comb begin
    bytes_needed_next   = bytes_needed;
    bytes_buffered_next = bytes_buffered;
    partial_value_next  = partial_value;
    pre                 = 3'd0;
    has_val             = 1'b0;
    val                 = {{(u2cp_pkg::CP_W-8){1'b0}}, b};

    if (b == 8'd0) begin
      pre                 = flush_n;
      bytes_needed_next   = 2'd0;
      bytes_buffered_next = 2'd0;
      partial_value_next  = '0;
    end else if (bytes_needed != 2'd0 && b[7:6] == u2cp_pkg::CONT_TAG) begin
      if (bytes_needed == 2'd1) begin
        has_val             = 1'b1;
        val                 = shifted;
        bytes_needed_next   = 2'd0;
        bytes_buffered_next = 2'd0;
        partial_value_next  = '0;
      end else begin
        bytes_needed_next   = bytes_needed - 2'd1;
        bytes_buffered_next = bytes_buffered + 2'd1;
        partial_value_next  = shifted;
      end
    end else begin
      // broken sequence (if any) flushes, then the byte decodes afresh
      pre                 = flush_n;
      bytes_needed_next   = 2'd0;
      bytes_buffered_next = 2'd0;
      partial_value_next  = '0;
      if (!b[7]) begin
        has_val = 1'b1;
      end else if (b[7:5] == u2cp_pkg::LEAD2_TAG) begin
        bytes_needed_next  = 2'd1;
        partial_value_next = {{(u2cp_pkg::CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == u2cp_pkg::LEAD3_TAG) begin
        bytes_needed_next  = 2'd2;
        partial_value_next = {{(u2cp_pkg::CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == u2cp_pkg::LEAD4_TAG) begin
        bytes_needed_next  = 2'd3;
        partial_value_next = {{(u2cp_pkg::CP_W-3){1'b0}}, b[2:0]};
      end else begin
        pre = flush_n + 3'd1;
      end
    end

    // end of string: whatever is still open goes out as errors
    if (item.end_of_string && bytes_needed_next != 2'd0) begin
      pre                 = pre + 3'd1 + {1'b0, bytes_buffered_next};
      bytes_needed_next   = 2'd0;
      bytes_buffered_next = 2'd0;
      partial_value_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_needed   <= 2'd0;
      bytes_buffered <= 2'd0;
      partial_value  <= '0;
    end else if (accept) begin
      bytes_needed   <= bytes_needed_next;
      bytes_buffered <= bytes_buffered_next;
      partial_value  <= partial_value_next;
    end
  end

  assign cmd_push     = accept && (pre != 3'd0 || has_val);
  assign cmd.pre_errs = pre;
  assign cmd.has_val  = has_val;
  assign cmd.done     = item.end_of_string || (b == 8'd0);
  assign cmd.val      = val;

endmodule

// ===== hdl/u2cp_queue.sv =====
// ----------------------------------------------------------------------------
// u2cp_queue
// Small command FIFO between the classifier and the result expander.
// ----------------------------------------------------------------------------
module u2cp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  u2cp_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output u2cp_pkg::cmd_t rd_data,
  output logic           q_full,
  output logic           q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u2cp_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign q_full  = (count == FULL_CNT);
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/u2cp_back.sv =====
// ----------------------------------------------------------------------------
// u2cp_back
// Result expander: walks each command one beat per cycle into an output
// register, while that register is free or being popped.
// ----------------------------------------------------------------------------
module u2cp_back (
  input  logic              clk,
  input  logic              rst,
  input  u2cp_pkg::cmd_t    head,
  input  logic              q_empty,
  output logic              q_pop,
  output u2cp_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);

  logic [2:0]        idx;
  logic [2:0]        total;
  logic              fire, final_beat;
  logic              out_valid;
  u2cp_pkg::result_t out_data;
  u2cp_pkg::result_t beat;

  assign total      = head.pre_errs + {2'b00, head.has_val};
  assign final_beat = (idx + 3'd1 == total);
  assign fire       = !q_empty && (!out_valid || pop);
  assign q_pop      = fire && final_beat;

  always_comb begin
    if (idx < head.pre_errs) begin
      beat.code_point = u2cp_pkg::REPLACEMENT;
      beat.is_error   = 1'b1;
    end else begin
      beat.code_point = head.val;
      beat.is_error   = 1'b0;
    end
    beat.last_of_run = final_beat;
    beat.string_done = final_beat && head.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        idx       <= final_beat ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= beat;
    end
  end

  assign result = out_data;
  assign empty  = !out_valid;

endmodule

// ===== hdl/utf8_to_code_point_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_unit
// UTF-8 byte stream to code point decoder, queue-style ports on both sides.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Each byte becomes at most one command in a
// QUEUE_DEPTH-entry queue; the result side then emits one code point per
// cycle while results are popped, so a byte that causes k results (up to
// four) holds the result side for k beats, and the byte side stalls only
// once the queue is full. The first result of a byte passes through the
// queue memory and then the expander's output register; the expander produces
// one beat per cycle from the head command while that register is free or popped.
module utf8_to_code_point_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  u2cp_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output u2cp_pkg::result_t result
);

  logic           accept;
  logic           cmd_push;
  u2cp_pkg::cmd_t cmd;
  u2cp_pkg::cmd_t head;
  logic           q_pop, q_empty;

  assign accept = push && !full;

  u2cp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  u2cp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_full  (full),
    .q_empty (q_empty)
  );

  u2cp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

// ===== hdl/u2cp_checker.sv =====
// ----------------------------------------------------------------------------
// u2cp_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u2cp_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input u2cp_pkg::result_t result
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result beat changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.string_done) |-> result.last_of_run)
    else $error("string_done without last_of_run");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_error) |-> (result.code_point == u2cp_pkg::REPLACEMENT))
    else $error("error beat without replacement code point");

  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

bind utf8_to_code_point_decoder_unit u2cp_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
